FILE: src/psdb_pkg.sv
// Shared types and constants for the point splat depth buffer.
// No dependencies; every other file of the block imports this package.
package psdb_pkg;

    localparam int STORE_ENTRIES = 16384;
    localparam int IDX_W         = 14;
    localparam int ACC_W         = 50;
    localparam int Q_W           = 33;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] STAT_STORED  = 3'd0;
    localparam logic [2:0] STAT_HIDDEN  = 3'd1;
    localparam logic [2:0] STAT_OUTSIDE = 3'd2;
    localparam logic [2:0] STAT_ZERO_W  = 3'd3;
    localparam logic [2:0] STAT_CLEARED = 3'd4;
    localparam logic [2:0] STAT_READ    = 3'd5;

    typedef struct packed {
        logic load;
        logic mul;
    } mac_ctrl_t;

endpackage

FILE: src/psdb_mac.sv
// Shared multiply-accumulate unit: one 32x32 product per cycle, floored to Q32.16.
// Depends on psdb_pkg.
module psdb_mac
    import psdb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mac_ctrl_t               ctrl,
    input  logic signed [31:0]      op_a,
    input  logic signed [31:0]      op_b,
    input  logic signed [31:0]      bias,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [63:0]      prod_reg;
    logic                    pvalid_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [47:0]      prod_floor;

    assign prod_floor = prod_reg[63:16];
    assign acc        = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
        end else begin
            pvalid_reg <= ctrl.mul;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.load) begin
            acc_reg <= ACC_W'(bias);
        end else if (pvalid_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_floor);
        end
    end

endmodule

FILE: src/psdb_div.sv
// Serial restoring divider: (num * 2^16) / den, truncated, saturated to 32 bits.
// Depends on psdb_pkg; one quotient bit per cycle.
module psdb_div
    import psdb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic signed [ACC_W-1:0] den,
    output logic                    done,
    output logic signed [31:0]      quot
);

    logic [ACC_W-1:0] mn;
    logic [ACC_W-1:0] md;
    logic [ACC_W-1:0] md_reg;
    logic [ACC_W-1:0] rem_reg;
    logic [Q_W-1:0]   dsh_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic             neg_reg;
    logic [ACC_W:0]   rem_sh;
    logic [ACC_W:0]   diff;
    logic             ge;
    logic             sat;

    assign mn = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign md = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);

    assign rem_sh = {rem_reg, dsh_reg[Q_W-1]};
    assign diff   = rem_sh - {1'b0, md_reg};
    assign ge     = !diff[ACC_W];

    always_comb begin
        if (neg_reg) begin
            sat  = ovf_reg || dsh_reg[32] || (dsh_reg[31] && (|dsh_reg[30:0]));
            quot = sat ? 32'sh8000_0000 : -$signed(dsh_reg[31:0]);
        end else begin
            sat  = ovf_reg || dsh_reg[32] || dsh_reg[31];
            quot = sat ? 32'sh7FFF_FFFF : $signed(dsh_reg[31:0]);
        end
    end

    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'(Q_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            md_reg  <= md;
            neg_reg <= num[ACC_W-1] ^ den[ACC_W-1];
            ovf_reg <= ({17'b0, mn[ACC_W-1:17]} >= md);
            rem_reg <= {17'b0, mn[ACC_W-1:17]};
            dsh_reg <= {mn[16:0], 16'b0};
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
            dsh_reg <= {dsh_reg[Q_W-2:0], ge};
        end
    end

endmodule

FILE: src/psdb_store.sv
// Depth image store: single-port RAM with registered read data.
// Depends on psdb_pkg.
module psdb_store
    import psdb_pkg::*;
(
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] addr,
    input  logic [31:0]      wdata,
    output logic [31:0]      rdata
);

    logic [31:0] mem_array [STORE_ENTRIES];
    logic [31:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

endmodule

FILE: src/point_splat_depth_buffer.sv
// Point splat depth buffer: keeps a depth image, projects points and z-tests them.
// Uses psdb_pkg, psdb_mac, psdb_div and psdb_store.
//
// Usage:
//   s_ channel carries one item per transfer: tuser is the kind (clear, point,
//   read), tdata holds point x, y, z and the read index. m_ channel returns one
//   result per item (status in tuser, depth and pixel index in tdata); an
//   unused kind gives no result. cfg_wr_en/cfg_addr/cfg_wdata load one coefficient
//   pair of a projection matrix row per write.
// Flow (one item at a time, s_tready high only when idle):
//   point: the work is done by the shared multiplier (12 products, one matrix
//          row at a time) and the serial divider (three quotients); outside
//          the image the z-test is skipped, and zero w skips the divider.
//   read: one registered store read. clear: one store entry written per cycle.
//   s_tready rises in the cycle after the result is loaded.
// Reset: the matrix returns to identity and a clearing pass fills every
//   store entry with the invalid depth; s_tready stays low meanwhile.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and its own result holds until the register frees.
module point_splat_depth_buffer
    import psdb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 128,
    parameter int IMAGE_HEIGHT = 128,
    parameter int ORTHOGRAPHIC = 0
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], read_index[109:96], zero pad
    input  logic [111:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_value[31:0], pixel_index[45:32], zero pad
    output logic [47:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);

    localparam logic [31:0] INVALID_DEPTH = (ORTHOGRAPHIC != 0) ? 32'h7FFF_FFFF : 32'h0;
    localparam int E_W = 17 + $clog2(IMAGE_WIDTH + 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RDW, S_MAC, S_ROW, S_DIV, S_PIX, S_IDX, S_CMP, S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [IDX_W-1:0]        clr_cnt_reg;
    logic                    clr_emit_reg;
    logic [127:0]            proj_row_reg [4];
    logic [1:0]              row_sel_reg;
    logic [1:0]              mac_cnt_reg;
    logic signed [31:0]      x_reg;
    logic signed [31:0]      y_reg;
    logic signed [31:0]      z_reg;
    logic signed [ACC_W-1:0] w_reg;
    logic signed [31:0]      qx_reg;
    logic signed [31:0]      qy_reg;
    logic signed [31:0]      qz_reg;
    logic signed [17:0]      px_reg;
    logic signed [17:0]      py_reg;
    logic                    inside_reg;
    logic [IDX_W-1:0]        e_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [2:0]              res_status_reg;
    logic [31:0]             res_value_reg;
    logic [IDX_W-1:0]        res_index_reg;
    logic                    m_tvalid_reg;
    logic [2:0]              m_status_reg;
    logic [31:0]             m_value_reg;
    logic [IDX_W-1:0]        m_index_reg;

    logic [127:0]            row_word;
    logic signed [31:0]      op_a;
    logic signed [31:0]      op_b;
    logic signed [31:0]      bias;
    mac_ctrl_t               mac_ctrl;
    logic signed [ACC_W-1:0] acc;
    logic                    div_start;
    logic                    div_done;
    logic signed [31:0]      quot;
    logic [E_W-1:0]          e_calc;
    logic                    s_xfer;
    logic                    out_free;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_addr;
    logic [31:0]             mem_wdata;
    logic [31:0]             mem_rdata;
    logic signed [31:0]      old_depth;
    logic                    take;
    logic signed [17:0]      px_calc;
    logic signed [17:0]      py_calc;

    function automatic logic signed [17:0] pixel_coord(input logic signed [31:0] q);
        logic signed [33:0] t;
        logic [33:0]        mag;
        t   = 34'(q) + 34'sd32768;
        mag = 34'(-t);
        if (!t[33]) begin
            return 18'(t[33:16]);
        end
        return -$signed({1'b0, mag[32:16]});
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_index_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

    assign row_word = proj_row_reg[row_sel_reg];
    assign op_a     = row_word[{mac_cnt_reg, 5'b0} +: 32];
    assign bias     = row_word[127:96];

    always_comb begin
        case (mac_cnt_reg)
            2'd0:    op_b = x_reg;
            2'd1:    op_b = y_reg;
            2'd2:    op_b = z_reg;
            default: op_b = x_reg;
        endcase
    end

    assign mac_ctrl.load = (state_reg == S_MAC) && (mac_cnt_reg == 2'd0);
    assign mac_ctrl.mul  = (state_reg == S_MAC) && (mac_cnt_reg != 2'd3);
    assign div_start     = (state_reg == S_ROW) && (row_sel_reg != 2'd3);

    assign px_calc = pixel_coord(qx_reg);
    assign py_calc = pixel_coord(qy_reg);
    assign e_calc  = E_W'(py_reg[16:0]) * E_W'(IMAGE_WIDTH) + E_W'(px_reg[16:0]);

    assign old_depth = $signed(mem_rdata);
    assign take      = (ORTHOGRAPHIC != 0) ? (qz_reg < old_depth) : (qz_reg > old_depth);

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = e_reg;
        mem_wdata = qz_reg;
        case (state_reg)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = INVALID_DEPTH;
            end
            S_IDLE: begin
                mem_addr = s_tdata[109:96];
            end
            S_IDX: begin
                mem_addr = e_calc[IDX_W-1:0];
            end
            S_CMP: begin
                mem_we = take;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    psdb_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .bias    (bias),
        .acc     (acc)
    );

    psdb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc),
        .den     (w_reg),
        .done    (div_done),
        .quot    (quot)
    );

    psdb_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 4; r++) begin
                proj_row_reg[r] <= 128'(ONE_Q16) << (32 * r);
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr[0]) begin
                proj_row_reg[cfg_addr[2:1]][127:64] <= cfg_wdata;
            end else begin
                proj_row_reg[cfg_addr[2:1]][63:0] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            clr_emit_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            row_sel_reg  <= '0;
            mac_cnt_reg  <= '0;
        end else begin
            if (state_reg == S_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(STORE_ENTRIES - 1)) begin
                        res_status_reg <= STAT_CLEARED;
                        res_value_reg  <= INVALID_DEPTH;
                        res_index_reg  <= '0;
                        state_reg      <= clr_emit_reg ? S_EMIT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_xfer) begin
                        x_reg      <= s_tdata[31:0];
                        y_reg      <= s_tdata[63:32];
                        z_reg      <= s_tdata[95:64];
                        rd_idx_reg <= s_tdata[109:96];
                        case (s_tuser)
                            KIND_CLEAR: begin
                                clr_cnt_reg  <= '0;
                                clr_emit_reg <= 1'b1;
                                state_reg    <= S_CLR;
                            end
                            KIND_POINT: begin
                                row_sel_reg <= 2'd3;
                                mac_cnt_reg <= 2'd0;
                                state_reg   <= S_MAC;
                            end
                            KIND_READ: begin
                                state_reg <= S_RDW;
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RDW: begin
                    res_status_reg <= STAT_READ;
                    res_value_reg  <= mem_rdata;
                    res_index_reg  <= rd_idx_reg;
                    state_reg      <= S_EMIT;
                end
                S_MAC: begin
                    mac_cnt_reg <= mac_cnt_reg + 2'd1;
                    if (mac_cnt_reg == 2'd3) begin
                        state_reg <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (row_sel_reg == 2'd3) begin
                        w_reg <= acc;
                        if (acc == '0) begin
                            res_status_reg <= STAT_ZERO_W;
                            res_value_reg  <= '0;
                            res_index_reg  <= '0;
                            state_reg      <= S_EMIT;
                        end else begin
                            row_sel_reg <= 2'd0;
                            mac_cnt_reg <= 2'd0;
                            state_reg   <= S_MAC;
                        end
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        case (row_sel_reg)
                            2'd0:    qx_reg <= quot;
                            2'd1:    qy_reg <= quot;
                            default: qz_reg <= quot;
                        endcase
                        if (row_sel_reg == 2'd2) begin
                            state_reg <= S_PIX;
                        end else begin
                            row_sel_reg <= row_sel_reg + 2'd1;
                            mac_cnt_reg <= 2'd0;
                            state_reg   <= S_MAC;
                        end
                    end
                end
                S_PIX: begin
                    px_reg     <= px_calc;
                    py_reg     <= py_calc;
                    inside_reg <= !px_calc[17] && !py_calc[17]
                               && (px_calc < 18'sd0 + 18'(IMAGE_WIDTH))
                               && (py_calc < 18'sd0 + 18'(IMAGE_HEIGHT));
                    state_reg  <= S_IDX;
                end
                S_IDX: begin
                    e_reg          <= e_calc[IDX_W-1:0];
                    res_value_reg  <= qz_reg;
                    if (!inside_reg || (e_calc >= E_W'(STORE_ENTRIES))) begin
                        res_status_reg <= STAT_OUTSIDE;
                        res_index_reg  <= '0;
                        state_reg      <= S_EMIT;
                    end else begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    res_status_reg <= take ? STAT_STORED : STAT_HIDDEN;
                    res_index_reg  <= e_reg;
                    state_reg      <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_status_reg <= res_status_reg;
                        m_value_reg  <= res_value_reg;
                        m_index_reg  <= res_index_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/tb_point_splat_depth_buffer.sv
`timescale 1ns / 1ps
// Self-checking bench for point_splat_depth_buffer: streams clear, point and read
// transfers under several projection matrices and checks each result against a
// local z-buffer predictor. Depends on psdb_pkg and the block's RTL only.
module tb_point_splat_depth_buffer;
    import psdb_pkg::*;

    localparam int IMAGE_WIDTH  = 128;
    localparam int IMAGE_HEIGHT = 128;
    localparam int ORTHOGRAPHIC = 0;

    localparam logic [31:0] INVALID_DEPTH = ORTHOGRAPHIC ? 32'h7FFF_FFFF : 32'h0;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;
    localparam longint      Q1            = 65536;
    localparam longint      HALF          = 32768;

    localparam logic [2:0] CFG_ROW0_C01 = 3'd0;
    localparam logic [2:0] CFG_ROW0_C23 = 3'd1;
    localparam logic [2:0] CFG_ROW1_C01 = 3'd2;
    localparam logic [2:0] CFG_ROW1_C23 = 3'd3;
    localparam logic [2:0] CFG_ROW2_C01 = 3'd4;
    localparam logic [2:0] CFG_ROW2_C23 = 3'd5;
    localparam logic [2:0] CFG_ROW3_C01 = 3'd6;
    localparam logic [2:0] CFG_ROW3_C23 = 3'd7;

    localparam int TX_STREAM = 0;
    localparam int TX_BURSTY = 1;
    localparam int TX_SPARSE = 2;
    localparam int RX_OPEN   = 0;
    localparam int RX_CHOPPY = 1;
    localparam int RX_SLOW   = 2;

    localparam int TAIL_CYCLES = 300;
    localparam int LIMIT_NS    = 20_000_000;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      px;
        logic [31:0]      py;
        logic [31:0]      pz;
        logic [IDX_W-1:0] rd_idx;
    } splat_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      depth;
        logic [IDX_W-1:0] index;
    } splat_result_t;

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [47:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_addr  = '0;
    logic [63:0]  cfg_wdata = '0;

    point_splat_depth_buffer #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .ORTHOGRAPHIC (ORTHOGRAPHIC)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    logic [63:0]   proj_shadow [8];
    logic [31:0]   depth_shadow [STORE_ENTRIES];
    splat_item_t   splat_items [$];
    splat_result_t awaited_results [$];
    int            recent_targets [$];
    splat_item_t   cur_item;
    int            fail_cnt   = 0;
    int            tx_mode    = TX_STREAM;
    int            rx_mode    = RX_OPEN;
    int            gap_left   = 0;
    int            burst_left = 0;
    int            rx_hold    = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- queue helpers ----------------
    function automatic void add_item(splat_item_t it);
        splat_items = {splat_items, it};
    endfunction

    function automatic void add_expect(splat_result_t r);
        awaited_results = {awaited_results, r};
    endfunction

    // ---------------- predictor ----------------
    function automatic longint mat_coef(int r, int c);
        logic [63:0] pair;
        pair = proj_shadow[r * 2 + c / 2];
        return (c % 2) ? longint'($signed(pair[63:32])) : longint'($signed(pair[31:0]));
    endfunction

    function automatic longint row_dot(int r, longint x, longint y, longint z);
        return ((mat_coef(r, 0) * x) >>> 16) + ((mat_coef(r, 1) * y) >>> 16)
             + ((mat_coef(r, 2) * z) >>> 16) + mat_coef(r, 3);
    endfunction

    function automatic longint div_sat(longint num, longint den);
        bit          neg;
        bit [63:0]   mn, md, q;
        neg = (num < 0) != (den < 0);
        mn  = (num < 0) ? -num : num;
        md  = (den < 0) ? -den : den;
        q   = (mn << 16) / md;
        if (!neg)
            return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
        if (q > 64'h8000_0000)
            q = 64'h8000_0000;
        return -longint'(q);
    endfunction

    function automatic longint round_pixel(longint q);
        return (q + HALF) / Q1;
    endfunction

    function automatic splat_result_t depth_outcome(splat_item_t it);
        splat_result_t r;
        longint        x, y, z, w, col, row, dep, e;
        r = '0;
        if (it.kind == KIND_CLEAR) begin
            foreach (depth_shadow[i])
                depth_shadow[i] = INVALID_DEPTH;
            r.status = STAT_CLEARED;
            r.depth  = INVALID_DEPTH;
        end else if (it.kind == KIND_READ) begin
            r.status = STAT_READ;
            r.index  = it.rd_idx;
            r.depth  = depth_shadow[it.rd_idx];
        end else if (it.kind == KIND_POINT) begin
            x = $signed(it.px);
            y = $signed(it.py);
            z = $signed(it.pz);
            w = row_dot(3, x, y, z);
            if (w == 0) begin
                r.status = STAT_ZERO_W;
            end else begin
                col     = round_pixel(div_sat(row_dot(0, x, y, z), w));
                row     = round_pixel(div_sat(row_dot(1, x, y, z), w));
                dep     = div_sat(row_dot(2, x, y, z), w);
                r.depth = 32'(dep);
                if (col < 0 || col >= IMAGE_WIDTH || row < 0 || row >= IMAGE_HEIGHT ||
                    row * IMAGE_WIDTH + col >= STORE_ENTRIES) begin
                    r.status = STAT_OUTSIDE;
                end else begin
                    e       = row * IMAGE_WIDTH + col;
                    r.index = IDX_W'(e);
                    if (ORTHOGRAPHIC ? (dep < longint'($signed(depth_shadow[e])))
                                     : (dep > longint'($signed(depth_shadow[e])))) begin
                        depth_shadow[e] = 32'(dep);
                        r.status        = STAT_STORED;
                    end else begin
                        r.status = STAT_HIDDEN;
                    end
                end
            end
        end
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && cur_item.kind != KIND_UNUSED)
                add_expect(depth_outcome(cur_item));
            if (gap_left > 0 || splat_items.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                cur_item = splat_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, cur_item.rd_idx, cur_item.pz, cur_item.py, cur_item.px};
                s_tuser  <= cur_item.kind;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 6);
                    case (tx_mode)
                        TX_STREAM: gap_left = 0;
                        TX_BURSTY: gap_left = $urandom_range(0, 6);
                        default:   gap_left = $urandom_range(0, 220);
                    endcase
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    task automatic flag_mismatch(string tag, splat_result_t exp_r, splat_result_t got_r);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t %s: exp status %0d depth %h index %0d, got status %0d depth %h index %0d",
                     $time, tag, exp_r.status, exp_r.depth, exp_r.index,
                     got_r.status, got_r.depth, got_r.index);
    endtask

    always @(posedge aclk) begin
        splat_result_t got_r, exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_r = {m_tuser, m_tdata[31:0], m_tdata[32 +: IDX_W]};
                if (awaited_results.size() == 0) begin
                    flag_mismatch("unexpected transfer", '0, got_r);
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (got_r.status !== exp_r.status || got_r.depth !== exp_r.depth ||
                        got_r.index !== exp_r.index)
                        flag_mismatch("mismatch", exp_r, got_r);
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_mode == RX_CHOPPY && $urandom_range(0, 3) == 0) begin
                rx_hold = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else if (rx_mode == RX_SLOW && $urandom_range(0, 15) == 0) begin
                rx_hold = $urandom_range(10, 150);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    function automatic splat_item_t mk_item(logic [1:0] kind, longint x, longint y, longint z,
                                            int idx);
        splat_item_t it;
        it.kind   = kind;
        it.px     = 32'(x);
        it.py     = 32'(y);
        it.pz     = 32'(z);
        it.rd_idx = IDX_W'(idx);
        return it;
    endfunction

    function automatic splat_item_t mk_point(longint x, longint y, longint z);
        return mk_item(KIND_POINT, x, y, z, $urandom_range(0, STORE_ENTRIES - 1));
    endfunction

    function automatic splat_item_t mk_read(int idx);
        return mk_item(KIND_READ, $signed($urandom()), $signed($urandom()),
                       $signed($urandom()), idx);
    endfunction

    function automatic splat_item_t mk_other(logic [1:0] kind);
        return mk_item(kind, $signed($urandom()), $signed($urandom()), $signed($urandom()),
                       $urandom_range(0, STORE_ENTRIES - 1));
    endfunction

    function automatic splat_item_t pick_read();
        if (recent_targets.size() > 0 && $urandom_range(0, 9) < 7)
            return mk_read(recent_targets[$urandom_range(0, recent_targets.size() - 1)]);
        return mk_read($urandom_range(0, STORE_ENTRIES - 1));
    endfunction

    function automatic logic [63:0] pair(longint lo, longint hi);
        return {32'(hi), 32'(lo)};
    endfunction

    function automatic longint noise_coord(bit wide);
        if (wide)
            return longint'($signed($urandom()));
        return longint'($urandom_range(0, 134 * 65536)) - 3 * Q1;
    endfunction

    task automatic cfg_write(logic [2:0] addr, logic [63:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        proj_shadow[addr] = data;
    endtask

    task automatic load_matrix(logic [63:0] r0a, logic [63:0] r0b, logic [63:0] r1a,
                               logic [63:0] r1b, logic [63:0] r2a, logic [63:0] r2b,
                               logic [63:0] r3a, logic [63:0] r3b);
        cfg_write(CFG_ROW0_C01, r0a);
        cfg_write(CFG_ROW0_C23, r0b);
        cfg_write(CFG_ROW1_C01, r1a);
        cfg_write(CFG_ROW1_C23, r1b);
        cfg_write(CFG_ROW2_C01, r2a);
        cfg_write(CFG_ROW2_C23, r2b);
        cfg_write(CFG_ROW3_C01, r3a);
        cfg_write(CFG_ROW3_C23, r3b);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_camera(longint fx, longint cx, longint fy, longint cy, longint a,
                               longint b);
        load_matrix(pair(fx, 0), pair(cx, 0), pair(0, fy), pair(cy, 0),
                    pair(0, 0), pair(a, b), pair(0, 0), pair(Q1, 0));
    endtask

    task automatic drain();
        while (splat_items.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic set_pace(int tx, int rx);
        tx_mode = tx;
        rx_mode = rx;
    endtask

    // points aimed at chosen pixels through a pinhole camera (w = z)
    task automatic queue_camera_items(int n, longint fx, longint cx, longint fy, longint cy,
                                      int clears);
        int     u, v, pick;
        longint z, x, y;
        for (int i = 0; i < n; i++) begin
            if (clears > 0 && i % (n / (clears + 1)) == 0 && i > 0)
                add_item(mk_other(KIND_CLEAR));
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                u = ($urandom_range(0, 1) == 0) ? $urandom_range(60, 63)
                                                : int'($urandom_range(0, 133)) - 3;
                v = ($urandom_range(0, 1) == 0) ? $urandom_range(40, 42)
                                                : int'($urandom_range(0, 133)) - 3;
                case ($urandom_range(0, 9))
                    0:       z = -longint'($urandom_range(1, 8)) * Q1;
                    1, 2, 3: z = longint'($urandom_range(2, 4)) * Q1;
                    default: z = longint'($urandom_range(Q1, 64 * Q1));
                endcase
                x = ((longint'(u) * Q1 - cx + longint'($urandom_range(0, 65535)) - HALF) * z)
                    / fx;
                y = ((longint'(v) * Q1 - cy + longint'($urandom_range(0, 65535)) - HALF) * z)
                    / fy;
                add_item(mk_point(x, y, z));
                if (u >= 0 && u < IMAGE_WIDTH && v >= 0 && v < IMAGE_HEIGHT) begin
                    recent_targets = {recent_targets, v * IMAGE_WIDTH + u};
                    if (recent_targets.size() > 64)
                        void'(recent_targets.pop_front());
                end
            end else if (pick < 97) begin
                add_item(pick_read());
            end else begin
                add_item(mk_other(KIND_UNUSED));
            end
        end
    endtask

    task automatic queue_noise_items(int n, int wide_pct);
        int pick;
        bit wide;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            wide = $urandom_range(0, 99) < wide_pct;
            if (pick < 75)
                add_item(mk_point(noise_coord(wide), noise_coord(wide),
                                  wide ? noise_coord(1'b1)
                                       : longint'($signed($urandom())) >>> 8));
            else if (pick < 97)
                add_item(pick_read());
            else
                add_item(mk_other(KIND_UNUSED));
        end
    endtask

    // ---------------- test sequence ----------------
    initial begin
        proj_shadow[CFG_ROW0_C01] = pair(Q1, 0);
        proj_shadow[CFG_ROW0_C23] = pair(0, 0);
        proj_shadow[CFG_ROW1_C01] = pair(0, Q1);
        proj_shadow[CFG_ROW1_C23] = pair(0, 0);
        proj_shadow[CFG_ROW2_C01] = pair(0, 0);
        proj_shadow[CFG_ROW2_C23] = pair(Q1, 0);
        proj_shadow[CFG_ROW3_C01] = pair(0, 0);
        proj_shadow[CFG_ROW3_C23] = pair(0, Q1);
        foreach (depth_shadow[i])
            depth_shadow[i] = INVALID_DEPTH;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // identity matrix: pixel = round(x, y), depth = z
        set_pace(TX_STREAM, RX_OPEN);
        add_item(mk_read(0));
        add_item(mk_read(STORE_ENTRIES - 1));
        add_item(mk_point(0, 0, Q1));
        add_item(mk_point(0, 0, HALF));
        add_item(mk_point(0, 0, Q1));
        add_item(mk_point(26214, 0, 2 * Q1));
        add_item(mk_point(127 * Q1 + 26214, 127 * Q1 + 26214, 3 * Q1));
        add_item(mk_point(127 * Q1 + HALF, 5 * Q1, Q1));
        add_item(mk_point(-Q1 - HALF, 0, Q1));
        add_item(mk_point(-Q1 - HALF + 1, 0, Q1));
        add_item(mk_point(3 * Q1, -Q1 - HALF, Q1));
        add_item(mk_point(3 * Q1, 127 * Q1 + HALF, Q1));
        add_item(mk_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        add_item(mk_point(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000));
        add_item(mk_point(10 * Q1, 20 * Q1, -5 * Q1));
        add_item(mk_point(10 * Q1, 20 * Q1, 32'sh7FFF_FFFF));
        add_item(mk_read(20 * IMAGE_WIDTH + 10));
        add_item(mk_read(0));
        add_item(mk_other(KIND_UNUSED));
        add_item(mk_other(KIND_CLEAR));
        add_item(mk_read(STORE_ENTRIES - 1));
        add_item(mk_read(0));
        drain();

        // pinhole camera A: zero w, tiny w and extreme z first
        load_camera(64 * Q1, 64 * Q1, 64 * Q1, 64 * Q1, 0, Q1);
        set_pace(TX_BURSTY, RX_CHOPPY);
        add_item(mk_point(Q1, Q1, 0));
        add_item(mk_point(Q1, -Q1, 1));
        add_item(mk_point(-Q1, Q1, -1));
        add_item(mk_point(32'sh7FFF_FFFF, 0, 1));
        add_item(mk_point(0, 0, 32'sh7FFF_FFFF));
        add_item(mk_point(0, 0, -64'sh8000_0000));
        queue_camera_items(140, 64 * Q1, 64 * Q1, 64 * Q1, 64 * Q1, 0);
        drain();

        // fully random matrix, wide noise
        load_matrix({$urandom(), $urandom()}, {$urandom(), $urandom()},
                    {$urandom(), $urandom()}, {$urandom(), $urandom()},
                    {$urandom(), $urandom()}, {$urandom(), $urandom()},
                    {$urandom(), $urandom()}, {$urandom(), $urandom()});
        set_pace(TX_SPARSE, RX_SLOW);
        queue_noise_items(60, 60);
        drain();

        // register extremes
        load_matrix('0, '0, '0, '0, '0, '0, '0, '0);
        set_pace(TX_STREAM, RX_CHOPPY);
        queue_noise_items(8, 50);
        drain();
        load_matrix('1, '1, '1, '1, '1, '1, '1, '1);
        queue_noise_items(8, 50);
        drain();
        load_matrix({4{16'h8000}} ^ 64'h0000_0000_FFFF_FFFF, 64'h8000_0000_7FFF_FFFF,
                    64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF,
                    64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF,
                    64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF);
        queue_noise_items(8, 50);
        drain();

        // pinhole camera B, mirrored x, offset depth, clears mid-stream
        load_camera(-32 * Q1, 100 * Q1, 48 * Q1 + HALF, 20 * Q1, HALF, 2 * Q1);
        set_pace(TX_SPARSE, RX_CHOPPY);
        queue_camera_items(150, -32 * Q1, 100 * Q1, 48 * Q1 + HALF, 20 * Q1, 2);
        drain();

        // back to identity
        load_camera(Q1, 0, Q1, 0, Q1, 0);
        load_matrix(pair(Q1, 0), pair(0, 0), pair(0, Q1), pair(0, 0),
                    pair(0, 0), pair(Q1, 0), pair(0, 0), pair(0, Q1));
        set_pace(TX_BURSTY, RX_SLOW);
        add_item(mk_other(KIND_CLEAR));
        queue_noise_items(60, 10);
        drain();

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
src/psdb_pkg.sv
src/psdb_mac.sv
src/psdb_div.sv
src/psdb_store.sv
src/point_splat_depth_buffer.sv
tb/tb_point_splat_depth_buffer.sv
